### rtl/bbpu_pkg.sv
`timescale 1ns / 1ps

package bbpu_pkg;

   localparam int BUFFER_WORDS = 1024;
   localparam int WORD_BITS    = 32;
   localparam int ADDR_W       = $clog2(BUFFER_WORDS);
   localparam int BANK_DEPTH   = BUFFER_WORDS / 2;
   localparam int BANK_AW      = ADDR_W - 1;
   localparam int OFF_W        = $clog2(WORD_BITS);
   localparam int CURSOR_W     = 16;
   localparam int BASE_W       = 10;
   localparam int REGION_W     = 11;
   localparam int CSR_W        = 11;
   localparam int COUNT_W      = 6;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_W-1:0]  MAX_COUNT    = COUNT_W'(WORD_BITS);
   localparam logic [REGION_W-1:0] REGION_RESET = REGION_W'(100);

   localparam logic [1:0] OP_REWIND = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic CSR_BASE  = 1'b0;
   localparam logic CSR_WORDS = 1'b1;

   typedef enum logic [1:0] {
      KIND_REWIND,
      KIND_WRITE,
      KIND_READ,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [WORD_BITS-1:0]    data;
      logic [COUNT_W-1:0]      count;
   } item_type;

endpackage

### rtl/bbpu_ram.sv
`timescale 1ns / 1ps

module bbpu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bbpu_front.sv
`timescale 1ns / 1ps

module bbpu_front
   import bbpu_pkg::*;
(
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [39:0] req_tdata,
   input  logic        queue_full,
   input  logic        clearing,
   output logic        push,
   output item_type    item
);

   logic [COUNT_W-1:0] raw_count;

   assign raw_count  = req_tdata[WORD_BITS +: COUNT_W];
   assign req_tready = !queue_full && !clearing;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      item.data  = req_tdata[WORD_BITS-1:0];
      item.count = (raw_count > MAX_COUNT) ? MAX_COUNT : raw_count;
      case (req_tuser)
         OP_REWIND: item.kind = KIND_REWIND;
         OP_WRITE:  item.kind = KIND_WRITE;
         OP_READ:   item.kind = KIND_READ;
         default:   item.kind = KIND_NOP;
      endcase
   end

endmodule

### rtl/bbpu_queue.sv
`timescale 1ns / 1ps

module bbpu_queue
   import bbpu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item,
   output logic     full
);

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     fill_ff;

   assign head_valid = (fill_ff != '0);
   assign full       = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            entry_ff[wr_ptr_ff] <= push_item;
            wr_ptr_ff           <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/bbpu_back.sv
`timescale 1ns / 1ps

module bbpu_back
   import bbpu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata,
   input  logic                    head_valid,
   input  item_type                head_item,
   output logic                    pop,
   output logic                    clearing,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [39:0]             rsp_tdata
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS
   } state_type;

   state_type               state_ff;
   logic [BANK_AW-1:0]      clr_ff;
   logic [CURSOR_W-1:0]     cursor_ff;
   logic                    overflow_ff;
   logic [BASE_W-1:0]       base_ff;
   logic [REGION_W-1:0]     words_ff;

   logic                    is_write_ff;
   logic [WORD_BITS-1:0]    data_ff;
   logic [COUNT_W-1:0]      count_ff;
   logic [COUNT_W-1:0]      n_ff;
   logic [OFF_W-1:0]        sh_ff;
   logic                    odd_ff;
   logic                    short_ff;
   logic [BANK_AW-1:0]      even_addr_ff;
   logic [BANK_AW-1:0]      odd_addr_ff;

   logic                    rsp_valid_ff;
   logic [WORD_BITS-1:0]    rsp_read_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic                    rsp_overflow_ff;

   logic                    slot_free;
   logic                    is_access;
   logic                    rsp_load;
   logic [CURSOR_W-1:0]     cap;
   logic [CURSOR_W-1:0]     avail;
   logic                    short_hit;
   logic [COUNT_W-1:0]      n_move;
   logic [ADDR_W-1:0]       a0;
   logic [ADDR_W-1:0]       a1;
   logic [BANK_AW-1:0]      even_rd_addr;
   logic [BANK_AW-1:0]      odd_rd_addr;

   logic [WORD_BITS-1:0]    even_rd_data;
   logic [WORD_BITS-1:0]    odd_rd_data;
   logic [WORD_BITS-1:0]    w0;
   logic [WORD_BITS-1:0]    w1;
   logic [2*WORD_BITS-1:0]  window;
   logic [2*WORD_BITS-1:0]  low_mask;
   logic [2*WORD_BITS-1:0]  field_mask;
   logic [2*WORD_BITS-1:0]  new_window;
   logic [WORD_BITS-1:0]    read_value;
   logic                    commit;
   logic                    bank_we;
   logic [BANK_AW-1:0]      even_wr_addr;
   logic [BANK_AW-1:0]      odd_wr_addr;
   logic [WORD_BITS-1:0]    even_wr_data;
   logic [WORD_BITS-1:0]    odd_wr_data;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign clearing  = (state_ff == ST_CLEAR);
   assign is_access = head_item.kind inside {KIND_WRITE, KIND_READ};
   assign pop       = (state_ff == ST_IDLE) && head_valid && (is_access || slot_free);

   // room left in the region and the bits this item really moves
   assign cap       = {words_ff, {OFF_W{1'b0}}};
   assign avail     = (cursor_ff < cap) ? (cap - cursor_ff) : '0;
   assign short_hit = (CURSOR_W'(head_item.count) > avail);
   assign n_move    = short_hit ? avail[COUNT_W-1:0] : head_item.count;

   // the field spans word a0 and a1, which sit in opposite banks
   assign a0 = ADDR_W'(32'(base_ff) + 32'(cursor_ff[CURSOR_W-1:OFF_W]));
   assign a1 = a0 + 1'b1;
   assign even_rd_addr = a0[0] ? a1[ADDR_W-1:1] : a0[ADDR_W-1:1];
   assign odd_rd_addr  = a0[0] ? a0[ADDR_W-1:1] : a1[ADDR_W-1:1];

   assign w0         = odd_ff ? odd_rd_data : even_rd_data;
   assign w1         = odd_ff ? even_rd_data : odd_rd_data;
   assign window     = {w1, w0};
   assign low_mask   = (64'd1 << n_ff) - 64'd1;
   assign field_mask = low_mask << sh_ff;
   assign new_window = (window & ~field_mask)
                     | ((({{WORD_BITS{1'b0}}, data_ff}) & low_mask) << sh_ff);
   assign read_value = WORD_BITS'((window >> sh_ff) & low_mask);

   assign commit       = (state_ff == ST_ACCESS) && slot_free;
   assign rsp_load     = commit || (pop && !is_access);
   assign bank_we      = clearing || (commit && is_write_ff && (n_ff != '0));
   assign even_wr_addr = clearing ? clr_ff : even_addr_ff;
   assign odd_wr_addr  = clearing ? clr_ff : odd_addr_ff;
   assign even_wr_data = clearing ? '0
                       : (odd_ff ? new_window[2*WORD_BITS-1:WORD_BITS]
                                 : new_window[WORD_BITS-1:0]);
   assign odd_wr_data  = clearing ? '0
                       : (odd_ff ? new_window[WORD_BITS-1:0]
                                 : new_window[2*WORD_BITS-1:WORD_BITS]);

   bbpu_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (bank_we),
      .wr_addr (even_wr_addr),
      .wr_data (even_wr_data),
      .rd_en   (pop && is_access),
      .rd_addr (even_rd_addr),
      .rd_data (even_rd_data)
   );

   bbpu_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (bank_we),
      .wr_addr (odd_wr_addr),
      .wr_data (odd_wr_data),
      .rd_en   (pop && is_access),
      .rd_addr (odd_rd_addr),
      .rd_data (odd_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         overflow_ff  <= 1'b0;
         base_ff      <= '0;
         words_ff     <= REGION_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_BASE:  base_ff  <= csr_wdata[BASE_W-1:0];
               CSR_WORDS: words_ff <= csr_wdata[REGION_W-1:0];
               default:   base_ff  <= base_ff;
            endcase
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (pop) begin
                  case (head_item.kind)
                     KIND_WRITE, KIND_READ: begin
                        is_write_ff  <= (head_item.kind == KIND_WRITE);
                        data_ff      <= head_item.data;
                        count_ff     <= head_item.count;
                        n_ff         <= n_move;
                        sh_ff        <= cursor_ff[OFF_W-1:0];
                        odd_ff       <= a0[0];
                        short_ff     <= short_hit;
                        even_addr_ff <= even_rd_addr;
                        odd_addr_ff  <= odd_rd_addr;
                        state_ff     <= ST_ACCESS;
                     end
                     KIND_REWIND: begin
                        cursor_ff       <= '0;
                        overflow_ff     <= 1'b0;
                        rsp_read_ff     <= '0;
                        rsp_count_ff    <= '0;
                        rsp_overflow_ff <= 1'b0;
                     end
                     default: begin
                        rsp_read_ff     <= '0;
                        rsp_count_ff    <= '0;
                        rsp_overflow_ff <= overflow_ff;
                     end
                  endcase
               end
            end
            ST_ACCESS: begin
               if (commit) begin
                  cursor_ff       <= cursor_ff + CURSOR_W'(n_ff);
                  overflow_ff     <= overflow_ff || short_ff;
                  rsp_read_ff     <= is_write_ff ? '0 : read_value;
                  rsp_count_ff    <= count_ff;
                  rsp_overflow_ff <= overflow_ff || short_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_overflow_ff, rsp_count_ff, rsp_read_ff};

endmodule

### rtl/bounded_bit_packer_unpacker.sv
`timescale 1ns / 1ps

// Bounded LSB-first bit packer/unpacker. Requests write or read fields of 0 to 32 bits
// through one bit cursor into a region of 32-bit words (base and size set through the
// csr port while idle); bits past the region are dropped or read as zero and set a
// sticky overflow flag, and a rewind clears cursor and flag. Every request gives one
// response. A write or read first reads the two words that the field may span (even and odd
// memory banks, read in parallel); a write then merges the field and writes them back.
// Rewind and unused codes need no memory access. A 2-entry queue separates request intake
// from execution. After reset the store is cleared, during which req_tready is low.
module bounded_bit_packer_unpacker
   import bbpu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_tuser,   // operation
   input  logic [39:0]        req_tdata,   // write_data, bit_count
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [39:0]        rsp_tdata,   // read_data, bits_reported, overflow
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   logic     push;
   item_type push_item;
   logic     pop;
   logic     head_valid;
   item_type head_item;
   logic     queue_full;
   logic     clearing;

   bbpu_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .clearing   (clearing),
      .push       (push),
      .item       (push_item)
   );

   bbpu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .full       (queue_full)
   );

   bbpu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### tb/bbpu_checker.sv
`timescale 1ns / 1ps

module bbpu_checker
   import bbpu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [1:0]         req_tuser,   // operation
   input  logic [39:0]        req_tdata,   // write_data, bit_count
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [39:0]        rsp_tdata,   // read_data, bits_reported, overflow
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   output int                 fail_count = 0,
   output int                 pending_count = 0
);

   typedef struct packed {
      logic [WORD_BITS-1:0] read_data;
      logic [COUNT_W-1:0]   bits_reported;
      logic                 overflow;
   } response_fields;

   logic [BASE_W-1:0]    region_base;
   logic [REGION_W-1:0]  region_words;
   logic [CURSOR_W-1:0]  cursor_pos;
   logic                 overflow_seen;
   logic [WORD_BITS-1:0] shadow_store [BUFFER_WORDS];
   response_fields       expected_q [$];

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic response_fields pack_or_unpack(kind_type kind, logic [31:0] data,
                                                     logic [COUNT_W-1:0] count);
      response_fields r;
      int n;
      int cap;
      int addr;
      int i;
      r = '0;
      n = (count > MAX_COUNT) ? WORD_BITS : int'(count);
      cap = int'(region_words) * WORD_BITS;
      case (kind)
         KIND_REWIND: begin
            cursor_pos = '0;
            overflow_seen = 1'b0;
         end
         KIND_WRITE, KIND_READ: begin
            for (i = 0; i < n; i++) begin
               // bits past the region are dropped or read as zero, cursor holds
               if (int'(cursor_pos) + 1 > cap) begin
                  overflow_seen = 1'b1;
               end else begin
                  addr = (int'(region_base) + int'(cursor_pos[CURSOR_W-1:5])) % BUFFER_WORDS;
                  if (kind == KIND_WRITE)
                     shadow_store[addr][cursor_pos[4:0]] = data[i];
                  else
                     r.read_data[i] = shadow_store[addr][cursor_pos[4:0]];
                  cursor_pos = cursor_pos + 1'b1;
               end
            end
            r.bits_reported = COUNT_W'(n);
         end
         default: ;
      endcase
      r.overflow = overflow_seen;
      return r;
   endfunction

   always @(posedge clock) begin
      response_fields want;
      int w;
      if (reset) begin
         region_base = '0;
         region_words = REGION_RESET;
         cursor_pos = '0;
         overflow_seen = 1'b0;
         for (w = 0; w < BUFFER_WORDS; w++)
            shadow_store[w] = '0;
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("response with no request pending", rsp_tdata[31:0], 32'd0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[31:0] !== want.read_data)
                  report_mismatch("read_data", rsp_tdata[31:0], want.read_data);
               if (rsp_tdata[37:32] !== want.bits_reported)
                  report_mismatch("bits_reported", 32'(rsp_tdata[37:32]),
                                  32'(want.bits_reported));
               if (rsp_tdata[38] !== want.overflow)
                  report_mismatch("overflow", 32'(rsp_tdata[38]), 32'(want.overflow));
            end
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(pack_or_unpack(kind_type'(req_tuser), req_tdata[31:0],
                                                req_tdata[37:32]));
         if (csr_we) begin
            if (csr_index == CSR_BASE)
               region_base = csr_wdata[BASE_W-1:0];
            else
               region_words = csr_wdata[REGION_W-1:0];
         end
      end
      pending_count <= expected_q.size();
   end

endmodule

### tb/tb_bounded_bit_packer_unpacker.sv
`timescale 1ns / 1ps

module tb_bounded_bit_packer_unpacker;
   import bbpu_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [1:0]         req_tuser = '0;   // operation
   logic [39:0]        req_tdata = '0;   // write_data, bit_count
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [39:0]        rsp_tdata;        // read_data, bits_reported, overflow
   logic               csr_we = 1'b0;
   logic               csr_index = 1'b0;
   logic [CSR_W-1:0]   csr_wdata = '0;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int request_count = 0;
   int burst_left = 0;
   int stall_mode = 0;

   bounded_bit_packer_unpacker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bbpu_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response side back-pressure, pattern picked at random from four
   always @(posedge clock) begin
      if (cycle_count % 256 == 0)
         stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 2) != 0);
         2: rsp_tready <= ((cycle_count % 16) >= 5);
         default: rsp_tready <= ((cycle_count % 8) == 0);
      endcase
   end

   function automatic logic [COUNT_W-1:0] random_count();
      if ($urandom_range(0, 6) == 0)
         return COUNT_W'($urandom_range(33, 63));
      return COUNT_W'($urandom_range(0, 32));
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(kind_type kind, logic [31:0] data, logic [COUNT_W-1:0] count);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, count, data};
      do @(posedge clock); while (!req_tready);
      if (kind != KIND_NOP)
         request_count++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_region(logic [BASE_W-1:0] base, logic [REGION_W-1:0] words);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_BASE;
      csr_wdata <= {1'($urandom_range(0, 1)), base};
      @(posedge clock);
      csr_index <= CSR_WORDS;
      csr_wdata <= words;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // pack a few fields, rewind, unpack them again
   task automatic pack_then_unpack();
      logic [COUNT_W-1:0] counts [$];
      int len;
      len = $urandom_range(1, 12);
      send_request(KIND_REWIND, $urandom, random_count());
      repeat (len) begin
         counts.push_back(random_count());
         send_request(KIND_WRITE, random_word(), counts[$]);
      end
      send_request(KIND_REWIND, $urandom, random_count());
      foreach (counts[i])
         send_request(KIND_READ, $urandom,
                      ($urandom_range(0, 4) == 0) ? random_count() : counts[i]);
   endtask

   task automatic run_phase(logic [BASE_W-1:0] base, logic [REGION_W-1:0] words, int quota);
      int stop_at;
      write_region(base, words);
      stop_at = request_count + quota;
      while (request_count < stop_at) begin
         if ($urandom_range(0, 3) != 0)
            pack_then_unpack();
         else
            repeat ($urandom_range(1, 6))
               send_request(kind_type'($urandom_range(0, 3)), random_word(), random_count());
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset region, count edges and unused code
      send_request(KIND_WRITE, '1, 6'd32);
      send_request(KIND_WRITE, $urandom, 6'd0);
      send_request(KIND_WRITE, 32'hA5A5_5A5A, 6'd63);
      send_request(KIND_WRITE, 32'h0000_0001, 6'd1);
      send_request(KIND_WRITE, $urandom, 6'd33);
      send_request(KIND_NOP, '1, 6'd32);
      send_request(KIND_REWIND, '1, 6'd63);
      send_request(KIND_READ, '0, 6'd32);
      send_request(KIND_READ, '0, 6'd0);
      send_request(KIND_READ, '1, 6'd63);
      send_request(KIND_READ, '0, 6'd1);
      send_request(KIND_READ, '0, 6'd33);

      // one-word region at the top of the store, run past its end
      write_region(10'd1023, 11'd1);
      send_request(KIND_REWIND, '0, 6'd0);
      send_request(KIND_WRITE, '1, 6'd20);
      send_request(KIND_WRITE, '0, 6'd20);
      send_request(KIND_READ, '0, 6'd1);
      send_request(KIND_NOP, $urandom, 6'd5);
      send_request(KIND_REWIND, '0, 6'd0);
      send_request(KIND_READ, '0, 6'd32);

      // empty region
      write_region(10'd512, 11'd0);
      send_request(KIND_WRITE, '1, 6'd8);
      send_request(KIND_READ, '0, 6'd8);
      send_request(KIND_REWIND, '0, 6'd0);

      run_phase(10'd0, 11'd100, 200);
      run_phase(10'd1023, 11'd1024, 200);
      run_phase(10'd1000, 11'd50, 200);
      run_phase(BASE_W'($urandom), 11'd0, 150);
      run_phase(BASE_W'($urandom), 11'd1, 200);
      run_phase(BASE_W'($urandom), REGION_W'($urandom_range(2, 8)), 250);
      run_phase(10'd0, 11'd1024, 150);
      run_phase(BASE_W'($urandom), REGION_W'($urandom_range(0, 1024)), 250);

      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
